@@ sv/etfb_pkg.sv @@
`default_nettype none

package etfb_pkg;

    localparam int unsigned CNT_W    = 7;
    localparam int unsigned CFG_IDX_W = 8;

    // largest frame on the line, start byte included
    localparam logic [7:0] MAX_FRAME = 8'd100;

    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] XON_BYTE   = 8'h11;
    localparam logic [7:0] XOFF_BYTE  = 8'h13;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] TX_TYPE    = 8'h10;
    localparam logic [7:0] SUM_BASE   = 8'hFF;
    localparam logic [8:0] LEN_EXTRA  = 9'd14;

    localparam logic [63:0] DEST_RESET = 64'h0000_0000_0000_FFFF;
    localparam logic [15:0] NET_RESET  = 16'hFFFE;

    localparam logic [CFG_IDX_W-1:0] REG_DEST = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NET  = CFG_IDX_W'(1);

    typedef enum logic [4:0] {
        ST_START, ST_LENH, ST_LENL, ST_TYPE, ST_ID,
        ST_D7, ST_D6, ST_D5, ST_D4, ST_D3, ST_D2, ST_D1, ST_D0,
        ST_NETH, ST_NETL, ST_OPT1, ST_OPT2,
        ST_DATA, ST_CSUM, ST_DONE
    } t_step;

    typedef struct packed {
        logic [63:0] dest;
        logic [15:0] net;
    } t_cfg;

    typedef struct packed {
        logic       overflow;
        logic       frame_done;
        logic       run_last;
        logic [7:0] out_byte;
    } t_res;

    function automatic logic needs_escape(input logic [7:0] v);
        return (v == START_BYTE) || (v == ESC_BYTE) || (v == XON_BYTE) || (v == XOFF_BYTE);
    endfunction

endpackage

`default_nettype wire

@@ sv/etfb_cfg.sv @@
`default_nettype none

module etfb_cfg
    import etfb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]          i_cfg_data,
    output t_cfg                      o_cfg
);

    logic [63:0] r_dest;
    logic [15:0] r_net;

    assign o_cfg_ready = 1'b1;
    assign o_cfg.dest  = r_dest;
    assign o_cfg.net   = r_net;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest <= DEST_RESET;
            r_net  <= NET_RESET;
        end else if (i_cfg_valid) begin
            // unknown indexes are ignored
            case (i_cfg_index)
                REG_DEST: r_dest <= i_cfg_data;
                REG_NET:  r_net  <= i_cfg_data[15:0];
                default:  ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/etfb_seq.sv @@
`default_nettype none

module etfb_seq
    import etfb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_has_data,
    input  wire logic       i_first_item,
    input  wire logic       i_last_item,
    input  wire logic [7:0] i_payload_count,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    output t_res            o_res
);

    // held item
    logic       r_busy;
    logic       r_fresh;
    logic [7:0] r_data;
    logic       r_has;
    logic       r_first;
    logic       r_last;
    logic [7:0] r_count;

    // sequencer and frame state
    t_step            r_step;
    logic             r_half;
    logic [7:0]       r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic             r_in_frame;

    logic             fresh_first;
    logic [7:0]       sum_eff;
    logic [CNT_W-1:0] cnt_eff;
    logic             frame_eff;
    t_step            tail_step;
    t_step            cur;
    t_step            nxt;
    logic [8:0]       len9;
    logic [7:0]       v;
    logic             esc;
    logic             fits;
    logic             adds;
    logic             active;
    logic             emit;
    logic             marker;
    logic             advancing;
    logic             done_now;
    logic             accept;
    logic [7:0]       n_sum;
    logic [CNT_W-1:0] n_cnt;
    logic             n_in_frame;

    // a new first item restarts the checksum and byte count from zero and opens the frame
    assign fresh_first = r_fresh && r_first;
    assign sum_eff     = fresh_first ? 8'd0 : r_sum;
    assign cnt_eff     = fresh_first ? '0 : r_cnt;
    assign frame_eff   = fresh_first ? 1'b1 : r_in_frame;
    assign len9        = {1'b0, r_count} + LEN_EXTRA;

    // next-step logic
    always_comb begin
        if (r_has) begin
            tail_step = ST_DATA;
        end else if (r_last) begin
            tail_step = ST_CSUM;
        end else begin
            tail_step = ST_DONE;
        end

        if (!r_fresh) begin
            cur = r_step;
        end else if (r_first) begin
            cur = ST_START;
        end else if (r_in_frame) begin
            cur = tail_step;
        end else begin
            cur = ST_DONE;
        end

        unique case (cur)
            ST_OPT2: nxt = tail_step;
            ST_DATA: nxt = r_last ? ST_CSUM : ST_DONE;
            ST_CSUM: nxt = ST_DONE;
            ST_DONE: nxt = ST_DONE;
            default: nxt = t_step'(cur + 5'd1);
        endcase
    end

    // byte selection and per-step control
    always_comb begin
        adds = 1'b1;
        unique case (cur)
            ST_START: begin v = START_BYTE; adds = 1'b0; end
            ST_LENH:  begin v = {7'd0, len9[8]}; adds = 1'b0; end
            ST_LENL:  begin v = len9[7:0]; adds = 1'b0; end
            ST_TYPE:  v = TX_TYPE;
            ST_ID:    v = 8'd0;
            ST_D7:    v = i_cfg.dest[63:56];
            ST_D6:    v = i_cfg.dest[55:48];
            ST_D5:    v = i_cfg.dest[47:40];
            ST_D4:    v = i_cfg.dest[39:32];
            ST_D3:    v = i_cfg.dest[31:24];
            ST_D2:    v = i_cfg.dest[23:16];
            ST_D1:    v = i_cfg.dest[15:8];
            ST_D0:    v = i_cfg.dest[7:0];
            ST_NETH:  v = i_cfg.net[15:8];
            ST_NETL:  v = i_cfg.net[7:0];
            ST_OPT1:  v = 8'd0;
            ST_OPT2:  v = 8'd0;
            ST_DATA:  v = r_data;
            ST_CSUM:  begin v = SUM_BASE - sum_eff; adds = 1'b0; end
            default:  begin v = 8'd0; adds = 1'b0; end
        endcase

        esc  = (cur != ST_START) && needs_escape(v);
        fits = ({1'b0, cnt_eff} + (esc ? 8'd2 : 8'd1)) <= MAX_FRAME;

        active    = r_busy && (cur != ST_DONE);
        emit      = active && i_res_ready;
        marker    = !r_half && (cur != ST_START) && !fits;
        advancing = emit && !marker && (r_half || !esc);
        done_now  = r_busy && ((cur == ST_DONE) || (emit && marker)
                               || (advancing && (nxt == ST_DONE)));

        n_sum      = sum_eff + ((adds && !r_half && !marker) ? v : 8'd0);
        n_cnt      = marker ? cnt_eff : cnt_eff + 1'b1;
        n_in_frame = (marker || (advancing && (cur == ST_CSUM))) ? 1'b0 : frame_eff;

        o_res_valid = emit;
        if (marker) begin
            o_res.out_byte = 8'd0;
        end else if (r_half) begin
            o_res.out_byte = v ^ ESC_XOR;
        end else begin
            o_res.out_byte = esc ? ESC_BYTE : v;
        end
        o_res.overflow   = marker;
        o_res.frame_done = marker || (advancing && (cur == ST_CSUM));
        o_res.run_last   = marker || (advancing && (nxt == ST_DONE));
    end

    assign o_ready = !r_busy || done_now;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_fresh    <= 1'b0;
            r_half     <= 1'b0;
            r_step     <= ST_DONE;
            r_sum      <= 8'd0;
            r_cnt      <= '0;
            r_in_frame <= 1'b0;
        end else begin
            if (emit) begin
                r_sum      <= n_sum;
                r_cnt      <= n_cnt;
                r_in_frame <= n_in_frame;
                if (!marker && !r_half && esc) begin
                    r_step <= cur;
                end else begin
                    r_step <= nxt;
                end
            end
            if (accept) begin
                r_busy  <= 1'b1;
                r_fresh <= 1'b1;
                r_half  <= 1'b0;
            end else begin
                if (done_now) begin
                    r_busy <= 1'b0;
                end
                if (emit) begin
                    r_fresh <= 1'b0;
                    r_half  <= !marker && !r_half && esc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data  <= i_data_byte;
            r_has   <= i_has_data;
            r_first <= i_first_item;
            r_last  <= i_last_item;
            r_count <= i_payload_count;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cnt} <= MAX_FRAME)
        else $error("line byte count beyond frame limit");

    a_half_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> r_busy && !r_fresh)
        else $error("escape second half pending without a held item");

    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready && o_res.frame_done) |=> !r_in_frame)
        else $error("frame still open after its final byte");

    a_ovf_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready && o_res.overflow) |=> !r_half && !r_in_frame)
        else $error("sequencer kept going after an overflow marker");

endmodule

`default_nettype wire

@@ sv/etfb_skid.sv @@
`default_nettype none

module etfb_skid
    import etfb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_res i_res,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_res      o_res
);

    logic r_out_valid;
    logic r_skid_valid;
    t_res r_out;
    t_res r_skid;
    logic pop;
    logic push;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign pop     = r_out_valid && i_ready;
    assign push    = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            r_out_valid  <= r_skid_valid || push;
            r_skid_valid <= 1'b0;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (push) begin
            r_skid <= i_res;
        end
    end

endmodule

`default_nettype wire

@@ sv/escaped_api_tx_frame_builder_core.sv @@
`default_nettype none

// channel   | direction | transfer condition                | contents
// s_axis    | in        | s_axis_tvalid & s_axis_tready     | payload byte, count, markers
// m_axis    | out       | m_axis_tvalid & m_axis_tready     | one escaped line byte
// cfg write | in        | i_cfg_valid & o_cfg_ready         | register index and value
//
// one line byte per cycle while the output buffer has room: a payload byte gives one
// line byte, two when escaped, and the checksum adds one or two more; a first item
// puts 17 to 28 header bytes on the line. the byte sequencer builds this sequence.
// synchronous active-low reset closes any frame and restores the default addresses.
// a two-entry output buffer keeps the sequencer running until it fills;
// m_axis_tready never reaches s_axis_tready combinationally.

module escaped_api_tx_frame_builder_core
    import etfb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [15:0]          s_axis_tdata,   // data_byte, payload_count
    input  wire logic [1:0]           s_axis_tuser,   // has_data, first_item
    input  wire logic                 s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // out_byte
    output logic [1:0]                m_axis_tuser,   // frame_done, overflow
    output logic                      m_axis_tlast,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]          i_cfg_data
);

    t_cfg cfg;
    t_res seq_res;
    t_res out_res;
    logic seq_valid;
    logic skid_ready;

    etfb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    etfb_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_data_byte     (s_axis_tdata[7:0]),
        .i_has_data      (s_axis_tuser[0]),
        .i_first_item    (s_axis_tuser[1]),
        .i_last_item     (s_axis_tlast),
        .i_payload_count (s_axis_tdata[15:8]),
        .o_res_valid     (seq_valid),
        .i_res_ready     (skid_ready),
        .o_res           (seq_res)
    );

    etfb_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (seq_valid),
        .o_ready (skid_ready),
        .i_res   (seq_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata    = out_res.out_byte;
    assign m_axis_tlast    = out_res.run_last;
    assign m_axis_tuser[0] = out_res.frame_done;
    assign m_axis_tuser[1] = out_res.overflow;

endmodule

`default_nettype wire
